// ===== src/hbcd_pkg.sv =====
// Shared types, constants and helper functions for the HTTP body chunk decoder.
// Used by the interfaces, the decoder modules and the checker; no dependencies.
`default_nettype none

package hbcd_pkg;

    // Width of the chunk size accumulator and the body byte counter.
    localparam int SIZE_BITS = 32;
    localparam int COUNT_BITS = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_CHUNKED_ENABLE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BODY_LENGTH    = 2'd1;

    // Characters of interest on a size line.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [3:0] HEX_TEN  = 4'd10;

    typedef enum logic [2:0] {
        PH_LINE = 3'b001,
        PH_DATA = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_valid;
        logic       chunk_end;
        logic       message_done;
        logic       size_error;
    } out_item_t;

    typedef struct packed {
        logic                   chunked_enable;
        logic [COUNT_BITS-1:0]  body_length;
    } cfg_t;

    typedef struct packed {
        phase_t                 phase;
        logic [SIZE_BITS-1:0]   size_accum;
        logic                   line_has_digit;
        logic                   line_cut;
        logic [SIZE_BITS-1:0]   chunk_remaining;
        logic [COUNT_BITS-1:0]  body_count;
    } dec_state_t;

    // Bit 4 flags a hex digit; bits 3:0 carry its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CH_0 && c <= CH_9) begin
            r = {1'b1, c[3:0]};
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            r = {1'b1, 4'(c - CH_UP_A) + HEX_TEN};
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            r = {1'b1, 4'(c - CH_LO_A) + HEX_TEN};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/hbcd_if.sv =====
// Channel interfaces for the HTTP body chunk decoder: byte input, result output
// and configuration writes. Depends on hbcd_pkg.
`default_nettype none

interface hbcd_in_if import hbcd_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hbcd_out_if import hbcd_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hbcd_cfg_if import hbcd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== src/hbcd_cfg_regs.sv =====
// Configuration register file: chunked_enable and body_length.
// Depends on hbcd_pkg and hbcd_cfg_if.
`default_nettype none

module hbcd_cfg_regs import hbcd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    hbcd_cfg_if.sink    cfg,
    output cfg_t        cfg_values
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;

    // Writes to unknown indexes are accepted and dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_CHUNKED_ENABLE: cfg_next.chunked_enable = cfg.wdata[0];
                REG_BODY_LENGTH:    cfg_next.body_length = cfg.wdata[COUNT_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_values = cfg_reg;

endmodule

`default_nettype wire

// ===== src/hbcd_step.sv =====
// Next-state and result logic for one body byte of the decoder.
// Purely combinational; depends on hbcd_pkg.
`default_nettype none

module hbcd_step import hbcd_pkg::*;
(
    input  wire dec_state_t  st,
    input  wire cfg_t        cfg_values,
    input  wire in_item_t    item,
    output dec_state_t       st_next,
    output out_item_t        res
);

    dec_state_t            cur;
    logic [COUNT_BITS-1:0] count_inc;
    logic [SIZE_BITS-1:0]  rem_dec;
    logic [4:0]            hex;

    always_comb
    begin
        cur = st;
        if (item.new_message)
        begin
            cur.phase           = PH_LINE;
            cur.size_accum      = '0;
            cur.line_has_digit  = 1'b0;
            cur.line_cut        = 1'b0;
            cur.chunk_remaining = '0;
            cur.body_count      = '0;
        end
    end

    assign count_inc = cur.body_count + COUNT_BITS'(1);
    assign rem_dec   = cur.chunk_remaining - SIZE_BITS'(1);
    assign hex       = hex_decode(item.data_byte);

    always_comb
    begin
        st_next = cur;
        res     = '0;
        if (cur.phase == PH_DONE)
        begin
            res.message_done = 1'b1;
        end
        else if (!cfg_values.chunked_enable)
        begin
            if (cur.body_count >= cfg_values.body_length)
            begin
                st_next.phase    = PH_DONE;
                res.message_done = 1'b1;
            end
            else
            begin
                res.body_byte      = item.data_byte;
                res.body_valid     = 1'b1;
                st_next.body_count = count_inc;
                if (count_inc >= cfg_values.body_length)
                begin
                    st_next.phase    = PH_DONE;
                    res.message_done = 1'b1;
                end
            end
        end
        else if (cur.phase == PH_DATA)
        begin
            res.body_byte           = item.data_byte;
            res.body_valid          = 1'b1;
            st_next.chunk_remaining = rem_dec;
            if (rem_dec == '0)
            begin
                res.chunk_end = 1'b1;
                st_next.phase = PH_LINE;
            end
        end
        else if (item.data_byte == CH_LF)
        begin
            // A line without any digit counts as blank and is skipped.
            if (cur.line_has_digit && cur.size_accum == '0)
            begin
                st_next.phase    = PH_DONE;
                res.message_done = 1'b1;
            end
            else if (cur.line_has_digit)
            begin
                st_next.chunk_remaining = cur.size_accum;
                st_next.phase           = PH_DATA;
            end
            else
            begin
                st_next.phase = PH_LINE;
            end
            st_next.size_accum     = '0;
            st_next.line_has_digit = 1'b0;
            st_next.line_cut       = 1'b0;
        end
        else if (item.data_byte == CH_CR)
        begin
            st_next.line_cut = 1'b1;
        end
        else if (!cur.line_cut)
        begin
            if (!hex[4])
            begin
                res.size_error = 1'b1;
            end
            else
            begin
                // High digits fall off the top when the size overflows.
                st_next.size_accum     = {cur.size_accum[SIZE_BITS-5:0], hex[3:0]};
                st_next.line_has_digit = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/http_body_chunk_decoder_unit.sv =====
// HTTP body decoder, length-delimited or chunked. Each byte is registered on input
// and then decoded into the result register, which loads once it is free.
// Throughput: one byte per cycle, sustained under no backpressure.
// Asynchronous active-low reset clears configuration, decoder state and the valid
// flags of both pipeline registers. Depends on hbcd_pkg, hbcd_if, hbcd_cfg_regs, hbcd_step.
`default_nettype none

module http_body_chunk_decoder_unit import hbcd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    hbcd_in_if.sink     body_stream,
    hbcd_out_if.source  decoded,
    hbcd_cfg_if.sink    cfg
);

    cfg_t       cfg_values;
    dec_state_t state_reg;
    dec_state_t state_next;
    out_item_t  step_res;

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       res_valid_reg;
    out_item_t  res_reg;

    logic       res_free;
    logic       advance;

    hbcd_cfg_regs u_cfg_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_values (cfg_values)
    );

    hbcd_step u_step
    (
        .st         (state_reg),
        .cfg_values (cfg_values),
        .item       (in_item_reg),
        .st_next    (state_next),
        .res        (step_res)
    );

    // The result register frees up in the same cycle as it is taken.
    assign res_free          = !res_valid_reg || decoded.ready;
    assign advance           = in_valid_reg && res_free;
    assign body_stream.ready = !in_valid_reg || res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_LINE, default: '0};
        end
        else
        begin
            if (body_stream.ready)
            begin
                in_valid_reg <= body_stream.valid;
            end
            if (res_free)
            begin
                res_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (body_stream.valid && body_stream.ready)
        begin
            in_item_reg <= body_stream.data;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign decoded.valid = res_valid_reg;
    assign decoded.data  = res_reg;

endmodule

`default_nettype wire

// ===== src/hbcd_chk.sv =====
// Port-level checker for the HTTP body decoder, bound to the top level.
// Depends on hbcd_pkg and http_body_chunk_decoder_unit.
`default_nettype none

module hbcd_chk import hbcd_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.body_valid |-> out_data.body_byte == 8'h00)
        else $error("body_byte non-zero on a non-body result");

    a_chunk_end_body: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.chunk_end |-> out_data.body_valid && !out_data.message_done)
        else $error("chunk_end without a body byte");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.size_error |->
            !out_data.body_valid && !out_data.chunk_end && !out_data.message_done)
        else $error("size_error together with other result flags");

endmodule

bind http_body_chunk_decoder_unit hbcd_chk u_hbcd_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (decoded.valid),
    .out_ready (decoded.ready),
    .out_data  (decoded.data)
);

`default_nettype wire
